[design/fmpd_pkg.sv]
// Package: shared types, codes and constants of the flow-metered pump dispenser.
package fmpd_pkg;

  typedef enum logic [2:0] {
    MODE_TICK,
    MODE_TOTAL_RESET,
    MODE_QUEUE_ADJUST,
    MODE_QUEUE_RESET,
    MODE_QUICK_FILL,
    MODE_RUN,
    MODE_STOP,
    MODE_TOGGLE
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NO_SENSOR,
    STATUS_STALL
  } status_t;

  typedef enum logic [1:0] {
    LEVEL_LOW,
    LEVEL_FULL,
    LEVEL_OVER,
    LEVEL_BURST
  } level_t;

  localparam logic [1:0] REG_FULL_VOLUME     = 2'd0;
  localparam logic [1:0] REG_FLOW_DEADBAND   = 2'd1;
  localparam logic [1:0] REG_STALL_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_STALL_LIMIT     = 2'd3;

  localparam int FILL_W  = 48;
  localparam int QUEUE_W = 28;
  localparam int FLOW_W  = 19;
  localparam int THR_W   = 34;

  localparam logic signed [QUEUE_W-1:0] QUEUE_LIMIT = 28'sd119988000;
  localparam logic signed [FILL_W-1:0]  FILL_MAX = {1'b0, {(FILL_W-1){1'b1}}};
  localparam logic signed [FILL_W-1:0]  FILL_MIN = {1'b1, {(FILL_W-1){1'b0}}};
  localparam logic [3:0]                STALL_SAT = 4'd15;

  localparam logic [26:0] FULL_RESET        = 27'd1200000;
  localparam logic [9:0]  DEADBAND_RESET    = 10'd5;
  localparam logic [19:0] STALL_THR_RESET   = 20'd7200;
  localparam logic [3:0]  STALL_LIMIT_RESET = 4'd10;

  localparam logic [6:0] PCT_HI  = 7'd115;
  localparam logic [6:0] PCT_MID = 7'd104;
  localparam logic [6:0] PCT_LO  = 7'd96;

  localparam logic [THR_W-1:0] THR_HI_RESET  = THR_W'(FULL_RESET) * THR_W'(PCT_HI);
  localparam logic [THR_W-1:0] THR_MID_RESET = THR_W'(FULL_RESET) * THR_W'(PCT_MID);
  localparam logic [THR_W-1:0] THR_LO_RESET  = THR_W'(FULL_RESET) * THR_W'(PCT_LO);

  typedef struct packed {
    logic                      pump_on;
    logic                      valve_reverse;
    logic signed [FILL_W-1:0]  fill;
    logic signed [QUEUE_W-1:0] queue;
    status_t                   status;
    logic                      emptied;
  } result_t;

  function automatic logic signed [QUEUE_W-1:0] sat_queue(input logic signed [QUEUE_W:0] v);
    logic signed [QUEUE_W:0] lim;
    lim = {QUEUE_LIMIT[QUEUE_W-1], QUEUE_LIMIT};
    if (v > lim) begin
      return QUEUE_LIMIT;
    end else if (v < -lim) begin
      return -QUEUE_LIMIT;
    end else begin
      return v[QUEUE_W-1:0];
    end
  endfunction

endpackage

[design/flow_metered_pump_dispenser.sv]
// Top level: flow-metered pump dispenser with APB register port.
//
// Takes one command transfer per clock while in_ready is high; the whole state update
// for a command (deadband, trapezoid integration, stall count, queue draw and pump
// control) is done in the cycle it is accepted, since every command depends on the
// state the previous one left. The result is registered in the result stage, then the
// fill level is derived from it and registered in a second register stage, the output
// stage. Two results can be held while the output is stalled; input ready drops only
// when both are full. Level thresholds (115%, 104%, 96% of full volume) are recomputed
// when full_volume is written. Registers sit at byte addresses 0, 4, 8 and 12.
module flow_metered_pump_dispenser
  import fmpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                mode,
  input  logic signed [FLOW_W-1:0]  flow_sample,
  input  logic                      sensor_present,
  input  logic signed [QUEUE_W-1:0] queue_delta,
  input  logic [8:0]                fill_fraction,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      pump_on,
  output logic                      valve_reverse,
  output logic signed [FILL_W-1:0]  fill_volume,
  output logic signed [QUEUE_W-1:0] queue_volume,
  output logic [1:0]                status,
  output logic [1:0]                level,
  output logic                      queue_emptied,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // configuration
  logic [26:0]      full_volume;
  logic [9:0]       flow_deadband;
  logic [19:0]      stall_threshold;
  logic [3:0]       stall_limit;
  logic [THR_W-1:0] thr_hi, thr_mid, thr_lo;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_volume     <= FULL_RESET;
      flow_deadband   <= DEADBAND_RESET;
      stall_threshold <= STALL_THR_RESET;
      stall_limit     <= STALL_LIMIT_RESET;
      thr_hi          <= THR_HI_RESET;
      thr_mid         <= THR_MID_RESET;
      thr_lo          <= THR_LO_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FULL_VOLUME: begin
          full_volume <= pwdata[26:0];
          thr_hi      <= THR_W'(pwdata[26:0]) * THR_W'(PCT_HI);
          thr_mid     <= THR_W'(pwdata[26:0]) * THR_W'(PCT_MID);
          thr_lo      <= THR_W'(pwdata[26:0]) * THR_W'(PCT_LO);
        end
        REG_FLOW_DEADBAND:   flow_deadband   <= pwdata[9:0];
        REG_STALL_THRESHOLD: stall_threshold <= pwdata[19:0];
        REG_STALL_LIMIT:     stall_limit     <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FULL_VOLUME:     prdata = {5'd0, full_volume};
      REG_FLOW_DEADBAND:   prdata = {22'd0, flow_deadband};
      REG_STALL_THRESHOLD: prdata = {12'd0, stall_threshold};
      REG_STALL_LIMIT:     prdata = {28'd0, stall_limit};
    endcase
  end

  // dispenser state
  logic signed [FILL_W-1:0]  fill_acc, fill_acc_next;
  logic signed [QUEUE_W-1:0] queue_rem, queue_rem_next;
  logic signed [FLOW_W-1:0]  prev_flow, prev_flow_next;
  logic [3:0]                stall_ticks, stall_ticks_next;
  logic                      pump_running, pump_running_next;
  logic                      valve_state, valve_state_next;
  logic                      error_latched, error_latched_next;
  status_t                   error_kind, error_kind_next;
  logic                      emptied_next;

  // pipeline
  logic    accept, r1_move;
  logic    r1_valid;
  result_t r1, out_q;

  assign r1_move  = !out_valid || out_ready;
  assign in_ready = !r1_valid || r1_move;
  assign accept   = in_valid && in_ready;

  // tick datapath
  logic [FLOW_W-1:0]         flow_abs;
  logic signed [FLOW_W-1:0]  flow_eff;
  logic signed [FLOW_W:0]    dv;
  logic [FLOW_W:0]           dv_abs;
  logic signed [FILL_W:0]    fill_sum;
  logic signed [FILL_W-1:0]  fill_sat;
  logic [3:0]                stall_base, stall_inc;
  logic signed [QUEUE_W-1:0] q_tick;
  logic                      crossing;
  logic [35:0]               qf_prod;
  logic [QUEUE_W-1:0]        qf_shift;
  logic signed [QUEUE_W-1:0] qf_sat;

  assign flow_abs = flow_sample[FLOW_W-1] ? FLOW_W'(-flow_sample) : flow_sample;
  assign flow_eff = (flow_abs < {9'd0, flow_deadband}) ? '0 : flow_sample;
  assign dv       = {prev_flow[FLOW_W-1], prev_flow} + {flow_eff[FLOW_W-1], flow_eff};
  assign dv_abs   = dv[FLOW_W] ? (FLOW_W+1)'(-dv) : dv;
  assign fill_sum = {fill_acc[FILL_W-1], fill_acc}
                  + {{(FILL_W-FLOW_W){dv[FLOW_W]}}, dv};
  assign fill_sat = (fill_sum[FILL_W] != fill_sum[FILL_W-1])
                  ? (fill_sum[FILL_W] ? FILL_MIN : FILL_MAX)
                  : fill_sum[FILL_W-1:0];

  assign stall_base = pump_running ? stall_ticks : 4'd0;
  assign stall_inc  = (dv_abs < {1'b0, stall_threshold})
                    ? ((stall_base == STALL_SAT) ? STALL_SAT : stall_base + 4'd1)
                    : 4'd0;

  assign q_tick   = sat_queue({queue_rem[QUEUE_W-1], queue_rem}
                            - {{(QUEUE_W-FLOW_W){dv[FLOW_W]}}, dv});
  assign crossing = (queue_rem < 0 && q_tick > 0) || (queue_rem > 0 && q_tick < 0);

  assign qf_prod  = fill_fraction * full_volume;
  assign qf_shift = qf_prod[35:8];
  assign qf_sat   = (qf_shift > QUEUE_LIMIT) ? QUEUE_LIMIT : qf_shift;

  always_comb begin
    fill_acc_next      = fill_acc;
    queue_rem_next     = queue_rem;
    prev_flow_next     = prev_flow;
    stall_ticks_next   = stall_ticks;
    pump_running_next  = pump_running;
    valve_state_next   = valve_state;
    error_latched_next = error_latched;
    error_kind_next    = error_kind;
    emptied_next       = 1'b0;
    unique case (mode_t'(mode))
      MODE_TICK: begin
        stall_ticks_next = stall_base;
        if (!error_latched) begin
          if (!sensor_present) begin
            pump_running_next  = 1'b0;
            error_latched_next = 1'b1;
            error_kind_next    = STATUS_NO_SENSOR;
          end else begin
            fill_acc_next    = fill_sat;
            prev_flow_next   = flow_eff;
            stall_ticks_next = stall_inc;
            if (pump_running) begin
              queue_rem_next = q_tick;
              if (crossing) begin
                pump_running_next = 1'b0;
                queue_rem_next    = '0;
                emptied_next      = 1'b1;
              end
            end
            if (stall_inc > stall_limit) begin
              pump_running_next  = 1'b0;
              error_latched_next = 1'b1;
              error_kind_next    = STATUS_STALL;
            end
          end
        end
      end
      MODE_TOTAL_RESET: begin
        fill_acc_next      = '0;
        prev_flow_next     = '0;
        error_latched_next = 1'b0;
        error_kind_next    = STATUS_OK;
      end
      MODE_QUEUE_ADJUST: begin
        queue_rem_next = sat_queue({queue_rem[QUEUE_W-1], queue_rem}
                                 + {queue_delta[QUEUE_W-1], queue_delta});
      end
      MODE_QUEUE_RESET: queue_rem_next = '0;
      MODE_QUICK_FILL: begin
        queue_rem_next = qf_sat;
        if (qf_sat != 0 && !error_latched) begin
          valve_state_next  = 1'b0;
          pump_running_next = 1'b1;
        end
      end
      MODE_RUN: begin
        if (queue_rem != 0 && !error_latched) begin
          valve_state_next  = queue_rem < 0;
          pump_running_next = 1'b1;
        end
      end
      MODE_STOP: pump_running_next = 1'b0;
      MODE_TOGGLE: begin
        if (pump_running) begin
          pump_running_next = 1'b0;
        end else if (queue_rem != 0 && !error_latched) begin
          valve_state_next  = queue_rem < 0;
          pump_running_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_acc      <= '0;
      queue_rem     <= '0;
      prev_flow     <= '0;
      stall_ticks   <= '0;
      pump_running  <= 1'b0;
      valve_state   <= 1'b0;
      error_latched <= 1'b0;
      error_kind    <= STATUS_OK;
    end else if (accept) begin
      fill_acc      <= fill_acc_next;
      queue_rem     <= queue_rem_next;
      prev_flow     <= prev_flow_next;
      stall_ticks   <= stall_ticks_next;
      pump_running  <= pump_running_next;
      valve_state   <= valve_state_next;
      error_latched <= error_latched_next;
      error_kind    <= error_kind_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (accept) begin
      r1_valid <= 1'b1;
    end else if (r1_move) begin
      r1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r1.pump_on       <= pump_running_next;
      r1.valve_reverse <= valve_state_next;
      r1.fill          <= fill_acc_next;
      r1.queue         <= queue_rem_next;
      r1.status        <= error_latched_next ? error_kind_next : STATUS_OK;
      r1.emptied       <= emptied_next;
    end
  end

  // level stage: fill*100 against full*pct
  logic signed [FILL_W+6:0] fill_x100;
  level_t                   level_next;
  level_t                   out_level;

  assign fill_x100 = ((FILL_W+7)'(r1.fill) <<< 6) + ((FILL_W+7)'(r1.fill) <<< 5)
                   + ((FILL_W+7)'(r1.fill) <<< 2);

  always_comb begin
    if (fill_x100 > $signed((FILL_W+7)'(thr_hi))) begin
      level_next = LEVEL_BURST;
    end else if (fill_x100 > $signed((FILL_W+7)'(thr_mid))) begin
      level_next = LEVEL_OVER;
    end else if (fill_x100 > $signed((FILL_W+7)'(thr_lo))) begin
      level_next = LEVEL_FULL;
    end else begin
      level_next = LEVEL_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r1_move) begin
      out_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1_move && r1_valid) begin
      out_q     <= r1;
      out_level <= level_next;
    end
  end

  assign pump_on       = out_q.pump_on;
  assign valve_reverse = out_q.valve_reverse;
  assign fill_volume   = out_q.fill;
  assign queue_volume  = out_q.queue;
  assign status        = out_q.status;
  assign level         = out_level;
  assign queue_emptied = out_q.emptied;

  // checks
  a_queue_range: assert property (@(posedge clk) disable iff (rst)
    queue_rem <= QUEUE_LIMIT && queue_rem >= -QUEUE_LIMIT)
    else $error("queue outside saturation range");

  a_error_stops_pump: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !pump_running)
    else $error("pump running with error latched");

  a_emptied_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_emptied) |-> (!pump_on && queue_volume == 0))
    else $error("emptied result with pump on or queue left");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> r1_valid)
    else $error("accepted transfer lost before result stage");

endmodule
